### rtl/rks_pkg.sv
// Shared types, widths and helper functions for the running k-smallest sum block.
package rks_pkg;

  // Number of sorted cells that hold the smallest values.
  localparam int MAX_KEEP = 16;

  // Field widths of the ports.
  localparam int KEEP_W = 5;
  localparam int VAL_W  = 32;
  localparam int SUM_W  = 36;

  // Width of a fill count that must reach MAX_KEEP itself.
  localparam int CNT_W  = $clog2(MAX_KEEP + 1);
  // Width of an index into the cells.
  localparam int IDX_W  = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

  // Keep count after reset.
  localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(1);

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  // Control of one sorted cell for the item being processed.
  typedef struct packed {
    logic step;      // an item is processed this cycle
    logic occupied;  // the cell holds a value
    logic writable;  // the cell may take a new value
  } cell_ctl_t;

  // Result of the store for the item being processed.
  typedef struct packed {
    sum_t sum;
    logic full;
  } stat_t;

  // Keep count as used: zero reads as one, larger than the cell count saturates.
  function automatic cnt_t eff_keep(input logic [KEEP_W-1:0] k);
    cnt_t res;
    if (k == '0) begin
      res = CNT_W'(1);
    end else if (int'(k) > MAX_KEEP) begin
      res = CNT_W'(MAX_KEEP);
    end else begin
      res = CNT_W'(k);
    end
    return res;
  endfunction

endpackage

### rtl/rks_cell.sv
// One cell of the sorted insertion row that holds a single kept value.
module rks_cell
  import rks_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  val_t      sample,
  input  val_t      prev_value,
  input  logic      prev_lt,
  output val_t      value,
  output logic      lt
);

  val_t value_r;
  val_t value_nxt;

  // The new item goes before this cell when the cell is empty or holds more.
  assign lt = !ctl.occupied || (sample < value_r);

  // Keep the value, shift the lower neighbour up, or take the new item.
  always_comb begin
    if (!lt) begin
      value_nxt = value_r;
    end else if (prev_lt) begin
      value_nxt = prev_value;
    end else begin
      value_nxt = sample;
    end
  end

  // Held values need no reset: an empty cell is never read.
  always_ff @(posedge clk) begin
    if (ctl.step && ctl.writable) begin
      value_r <= value_nxt;
    end
  end

  assign value = value_r;

endmodule

### rtl/rks_store.sv
// Sorted store of the kept values with fill count and running sum.
module rks_store
  import rks_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  step,
  input  val_t  sample,
  input  logic  start,
  input  cnt_t  keep,
  output stat_t stat
);

  cnt_t count_r;
  cnt_t count_nxt;
  sum_t sum_r;
  sum_t sum_nxt;

  cnt_t cnt_eff;
  cnt_t cnt_m1;
  logic append;
  logic replace;
  logic [IDX_W-1:0] top_idx;
  val_t top_val;
  sum_t sum_base;
  logic signed [VAL_W:0] delta;

  val_t      cell_val [MAX_KEEP];
  logic      cell_lt  [MAX_KEEP];
  cell_ctl_t cell_ctl [MAX_KEEP];

  // A start item sees an empty store.
  assign cnt_eff  = start ? '0 : count_r;
  assign sum_base = start ? '0 : sum_r;
  assign append   = (cnt_eff < keep);

  // Row of cells kept in ascending order; the largest sits at the top of the fill.
  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    assign cell_ctl[i].step     = step;
    assign cell_ctl[i].occupied = (CNT_W'(i) < cnt_eff);
    assign cell_ctl[i].writable = (CNT_W'(i) < cnt_eff) ||
                                  (append && (CNT_W'(i) == cnt_eff));
    if (i == 0) begin : g_first
      rks_cell u_cell (
        .clk        (clk),
        .ctl        (cell_ctl[i]),
        .sample     (sample),
        .prev_value (sample),
        .prev_lt    (1'b0),
        .value      (cell_val[i]),
        .lt         (cell_lt[i])
      );
    end else begin : g_next
      rks_cell u_cell (
        .clk        (clk),
        .ctl        (cell_ctl[i]),
        .sample     (sample),
        .prev_value (cell_val[i-1]),
        .prev_lt    (cell_lt[i-1]),
        .value      (cell_val[i]),
        .lt         (cell_lt[i])
      );
    end
  end

  // The largest held value and whether the new item displaces it.
  assign cnt_m1  = cnt_eff - CNT_W'(1);
  assign top_idx = cnt_m1[IDX_W-1:0];
  assign top_val = cell_val[top_idx];
  assign replace = !append && cell_lt[top_idx];

  // Change of the sum, then the wrapped sum itself.
  always_comb begin
    if (replace) begin
      delta = {sample[VAL_W-1], sample} - {top_val[VAL_W-1], top_val};
    end else if (append) begin
      delta = {sample[VAL_W-1], sample};
    end else begin
      delta = '0;
    end
  end

  assign sum_nxt   = sum_base + {{(SUM_W-VAL_W-1){delta[VAL_W]}}, delta};
  assign count_nxt = cnt_eff + CNT_W'(append);

  assign stat.sum  = sum_nxt;
  assign stat.full = (count_nxt >= keep);

  // Fill count and sum registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
    end else if (step) begin
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
    end
  end

endmodule

### rtl/running_k_smallest_sum.sv
// Top level of the running sum of the keep_count smallest values.
//
//  channel  direction  handshake           payload
//  in_      input      in_valid / in_stall  in_sample_value, in_start_new
//  out_     output     out_valid/out_stall  out_running_sum, out_set_full
//  cfg_     input      cfg_wr_en            cfg_keep_count
//
// An item is registered in the input register on acceptance and its result in the
// output register once that frees; one item is taken in every cycle while out_stall is low.
// The rate is set by the sorted insertion, which shifts the whole cell row at once.
// Reset clears the fill count, the sum and both valid flags; keep_count reads 1.
// A stalled result holds the output register and then the input register,
// after which in_stall rises; no clearing pass is needed after reset.
module running_k_smallest_sum
  import rks_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  val_t              in_sample_value,
  input  logic              in_start_new,
  output logic              out_valid,
  input  logic              out_stall,
  output sum_t              out_running_sum,
  output logic              out_set_full,
  input  logic              cfg_wr_en,
  input  logic [KEEP_W-1:0] cfg_keep_count
);

  logic [KEEP_W-1:0] keep_r;
  cnt_t              keep_eff;

  logic s1_valid_r;
  logic s1_valid_nxt;
  val_t s1_sample_r;
  logic s1_start_r;

  logic  out_valid_r;
  logic  out_valid_nxt;
  sum_t  out_sum_r;
  logic  out_full_r;

  logic  advance;
  logic  step;
  logic  in_take;
  stat_t stat;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r <= KEEP_RESET;
    end else if (cfg_wr_en) begin
      keep_r <= cfg_keep_count;
    end
  end

  assign keep_eff = eff_keep(keep_r);

  // Pipeline flow: the result register frees when empty or taken.
  assign advance  = !out_valid_r || !out_stall;
  assign step     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !advance);
  assign out_valid_nxt = step || (out_valid_r && out_stall);

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input item register.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_sample_r <= in_sample_value;
      s1_start_r  <= in_start_new;
    end
  end

  // Sorted store and sum.
  rks_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .sample (s1_sample_r),
    .start  (s1_start_r),
    .keep   (keep_eff),
    .stat   (stat)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (step) begin
      out_sum_r  <= stat.sum;
      out_full_r <= stat.full;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_running_sum = out_sum_r;
  assign out_set_full    = out_full_r;

`ifndef SYNTHESIS
  // A result appears only for an item that waited in the input register.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result appeared without an item in the input register");

  // A taken result with nothing behind it leaves the output empty.
  a_result_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !s1_valid_r) |=> !out_valid_r)
    else $error("result repeated after it was taken");

  // A restart with a keep count of one fills the store at once.
  a_restart_full: assert property (@(posedge clk) disable iff (!rst_n)
    (step && s1_start_r && (keep_eff == CNT_W'(1))) |=> out_set_full)
    else $error("restart with keep count one did not report a full set");
`endif

endmodule

### verif/tb.sv
// Self-checking testbench for the running sum of the keep_count smallest values.
module tb
  import rks_pkg::*;
();

  // Stream values at the ends of the signed range and the sums they give.
  localparam val_t VAL_MAX    = 32'sh7FFFFFFF;
  localparam val_t VAL_MIN    = 32'sh80000000;
  localparam sum_t SUM_TOP    = 36'sh7FFFFFFF0;
  localparam sum_t SUM_BOTTOM = 36'sh800000000;
  localparam int   N_DIR      = 21;

  // One expected result: the sum of the kept values and the full flag.
  typedef struct {
    sum_t sum;
    logic full;
  } sum_rec_t;

  // One row of the directed stimulus: an optional keep count write, then the item,
  // repeated; the typed result, where given, applies to the last repetition.
  typedef struct {
    logic              wr_keep;
    logic [KEEP_W-1:0] keep;
    val_t              value;
    logic              start;
    int                reps;
    logic              typed;
    sum_t              sum;
    logic              full;
  } dir_row_t;

  logic              clk;
  logic              rst_n           = 1'b0;
  logic              in_valid        = 1'b0;
  logic              in_stall;
  val_t              in_sample_value = '0;
  logic              in_start_new    = 1'b0;
  logic              out_valid;
  logic              out_stall       = 1'b0;
  sum_t              out_running_sum;
  logic              out_set_full;
  logic              cfg_wr_en       = 1'b0;
  logic [KEEP_W-1:0] cfg_keep_count  = '0;

  // Own copy of the block's state for prediction.
  val_t              kept_vals [MAX_KEEP];
  int                kept_count;
  sum_t              kept_sum;
  logic [KEEP_W-1:0] keep_reg;

  sum_rec_t          sums_due [$];
  dir_row_t          dir_rows [N_DIR];
  int                err_count     = 0;
  int                send_idle_pct = 0;
  int                stall_pct     = 0;

  running_k_smallest_sum u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_value (in_sample_value),
    .in_start_new    (in_start_new),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_running_sum (out_running_sum),
    .out_set_full    (out_set_full),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_keep_count  (cfg_keep_count)
  );

  // Clock with a period of ten units.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    err_count++;
  endtask

  // Takes one item into the kept set and returns the sum and full flag after it.
  function automatic void predict_k_smallest(input val_t v, input logic s,
                                             output sum_t psum, output logic pfull);
    int lim;
    int top;
    lim = (keep_reg == '0) ? 1 : ((int'(keep_reg) > MAX_KEEP) ? MAX_KEEP : int'(keep_reg));
    if (s) begin
      kept_count = 0;
      kept_sum   = '0;
    end
    if (kept_count < lim) begin
      kept_vals[kept_count] = v;
      kept_count++;
      kept_sum = kept_sum + sum_t'(v);
    end else begin
      // The lowest-index entry among equal largest values is the one replaced.
      top = 0;
      for (int i = 1; i < kept_count; i++) begin
        if (kept_vals[i] > kept_vals[top]) begin
          top = i;
        end
      end
      if (v < kept_vals[top]) begin
        kept_sum       = kept_sum - sum_t'(kept_vals[top]) + sum_t'(v);
        kept_vals[top] = v;
      end
    end
    psum  = kept_sum;
    pfull = (kept_count >= lim);
  endfunction

  // Picks a stream value: range ends, full random, and narrow ranges that give ties.
  function automatic val_t pick_value();
    val_t v;
    case ($urandom_range(9))
      0:       v = VAL_MAX;
      1:       v = VAL_MIN;
      2, 3:    v = val_t'($urandom);
      8, 9:    v = val_t'(int'($urandom_range(2000)) - 1000);
      default: v = val_t'(int'($urandom_range(40)) - 20);
    endcase
    return v;
  endfunction

  // Picks a keep count, often one of the extremes or a saturating value.
  function automatic logic [KEEP_W-1:0] pick_keep();
    logic [KEEP_W-1:0] k;
    case ($urandom_range(7))
      0:       k = 5'd0;
      1:       k = 5'd1;
      2:       k = 5'd16;
      3:       k = 5'd17;
      4:       k = 5'd31;
      default: k = KEEP_W'($urandom_range(16, 1));
    endcase
    return k;
  endfunction

  // Offers one item from a falling edge and records its expected result on acceptance.
  task automatic send_item(input val_t v, input logic s, input logic typed,
                           input sum_t tsum, input logic tfull);
    sum_t     psum;
    logic     pfull;
    sum_rec_t rec;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_sample_value <= v;
    in_start_new    <= s;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    predict_k_smallest(v, s, psum, pfull);
    rec.sum  = typed ? tsum : psum;
    rec.full = typed ? tfull : pfull;
    sums_due.push_back(rec);
    @(negedge clk);
  endtask

  // Writes the keep count once the block has drained every result.
  task automatic write_keep(input logic [KEEP_W-1:0] k);
    in_valid <= 1'b0;
    while (sums_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
    cfg_keep_count <= k;
    cfg_wr_en      <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    keep_reg = k;
  endtask

  // The receiver stalls at random at the rate of the current phase.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Compares each accepted result with the oldest expected one.
  always @(posedge clk) begin
    sum_rec_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (sums_due.size() == 0) begin
        report_mismatch($sformatf("result %0d/%0b with no item pending",
                                  out_running_sum, out_set_full));
      end else begin
        want = sums_due.pop_front();
        if (out_running_sum !== want.sum) begin
          report_mismatch($sformatf("running_sum got %0d expected %0d",
                                    out_running_sum, want.sum));
        end
        if (out_set_full !== want.full) begin
          report_mismatch($sformatf("set_full got %0b expected %0b",
                                    out_set_full, want.full));
        end
      end
    end
  end

  // Main sequence: reset, directed table, random phases, drain and verdict.
  initial begin
    int n;
    dir_rows = '{
      '{1'b0, 5'd0,  32'sd5,   1'b1, 1,  1'b1, 36'sd5,   1'b1},
      '{1'b0, 5'd0,  -32'sd3,  1'b0, 1,  1'b1, -36'sd3,  1'b1},
      '{1'b0, 5'd0,  32'sd7,   1'b0, 1,  1'b1, -36'sd3,  1'b1},
      '{1'b0, 5'd0,  VAL_MAX,  1'b1, 1,  1'b1, VAL_MAX,  1'b1},
      '{1'b0, 5'd0,  VAL_MIN,  1'b0, 1,  1'b1, VAL_MIN,  1'b1},
      '{1'b1, 5'd16, VAL_MAX,  1'b1, 16, 1'b1, SUM_TOP,  1'b1},
      '{1'b0, 5'd0,  VAL_MIN,  1'b0, 16, 1'b1, SUM_BOTTOM, 1'b1},
      '{1'b0, 5'd0,  32'sd0,   1'b1, 1,  1'b1, 36'sd0,   1'b0},
      '{1'b1, 5'd0,  32'sd10,  1'b1, 1,  1'b1, 36'sd10,  1'b1},
      '{1'b0, 5'd0,  32'sd20,  1'b0, 1,  1'b1, 36'sd10,  1'b1},
      '{1'b1, 5'd31, 32'sd1,   1'b1, 1,  1'b1, 36'sd1,   1'b0},
      '{1'b0, 5'd0,  -32'sd1,  1'b0, 1,  1'b1, 36'sd0,   1'b0},
      '{1'b1, 5'd17, VAL_MAX,  1'b1, 16, 1'b1, SUM_TOP,  1'b1},
      '{1'b0, 5'd0,  VAL_MAX,  1'b0, 1,  1'b1, SUM_TOP,  1'b1},
      '{1'b1, 5'd4,  32'sd100, 1'b1, 4,  1'b1, 36'sd400, 1'b1},
      '{1'b1, 5'd2,  32'sd50,  1'b0, 1,  1'b1, 36'sd350, 1'b1},
      '{1'b0, 5'd0,  32'sd100, 1'b0, 1,  1'b1, 36'sd350, 1'b1},
      '{1'b0, 5'd0,  32'sd60,  1'b0, 1,  1'b0, 36'sd0,   1'b0},
      '{1'b0, 5'd0,  -32'sd7,  1'b0, 1,  1'b0, 36'sd0,   1'b0},
      '{1'b0, 5'd0,  32'sd0,   1'b1, 1,  1'b1, 36'sd0,   1'b0},
      '{1'b1, 5'd1,  -32'sd5,  1'b0, 1,  1'b0, 36'sd0,   1'b0}
    };
    kept_count = 0;
    kept_sum   = '0;
    keep_reg   = KEEP_RESET;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: range ends, saturating keep counts, a lowered keep count and ties.
    for (int r = 0; r < N_DIR; r++) begin
      if (dir_rows[r].wr_keep) begin
        write_keep(dir_rows[r].keep);
      end
      for (int i = 0; i < dir_rows[r].reps; i++) begin
        send_item(dir_rows[r].value, dir_rows[r].start && (i == 0),
                  dir_rows[r].typed && (i == dir_rows[r].reps - 1),
                  dir_rows[r].sum, dir_rows[r].full);
      end
    end

    // Random part: four idling phases, each with several keep count settings.
    // Restarts are rare so that the kept set fills and values get replaced.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 68; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 68; end
        default: begin send_idle_pct = 18; stall_pct = 18; end
      endcase
      for (int b = 0; b < 6; b++) begin
        write_keep(pick_keep());
        n = $urandom_range(86, 50);
        for (int i = 0; i < n; i++) begin
          send_item(pick_value(), (i == 0) ? logic'($urandom_range(1)) :
                    ($urandom_range(24) == 0), 1'b0, '0, 1'b0);
        end
      end
    end

    // Drain every pending result, then allow for the pipeline latency.
    in_valid <= 1'b0;
    while (sums_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (8) @(negedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Ends a run that hangs.
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
